/* rtl/smum_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smum_pkg
// Shared types and codes for the serial MIDI to USB-MIDI packet encoder.
// ----------------------------------------------------------------------------
package smum_pkg;

	// parser phase, seven codes used, the eighth behaves as unknown
	typedef enum logic [2:0] {
		PH_UNKNOWN = 3'd0,
		PH_ONE     = 3'd1,
		PH_TWO_A   = 3'd2,
		PH_TWO_B   = 3'd3,
		PH_SX0     = 3'd4,
		PH_SX1     = 3'd5,
		PH_SX2     = 3'd6
	} phase_t;

	// code index numbers
	localparam logic [3:0] CIN_SYS_TWO   = 4'h2;
	localparam logic [3:0] CIN_SYS_THREE = 4'h3;
	localparam logic [3:0] CIN_SX_START  = 4'h4;
	localparam logic [3:0] CIN_SX_END1   = 4'h5;
	localparam logic [3:0] CIN_SX_END2   = 4'h6;
	localparam logic [3:0] CIN_SX_END3   = 4'h7;
	localparam logic [3:0] CIN_RT        = 4'hf;

	// status bytes
	localparam logic [7:0] ST_RT_LOW   = 8'hf8;
	localparam logic [7:0] ST_SX_START = 8'hf0;
	localparam logic [7:0] ST_MTC      = 8'hf1;
	localparam logic [7:0] ST_SPP      = 8'hf2;
	localparam logic [7:0] ST_SONG     = 8'hf3;
	localparam logic [7:0] ST_TUNE     = 8'hf6;
	localparam logic [7:0] ST_SX_END   = 8'hf7;
	localparam logic [7:0] ST_ONE_LOW  = 8'hc0;
	localparam logic [7:0] ST_ONE_HIGH = 8'hdf;
	localparam logic [3:0] NIB_SYSTEM  = 4'hf;

	// one event packet
	typedef struct packed {
		logic [7:0] third_byte;
		logic [7:0] second_byte;
		logic [7:0] first_byte;
		logic [3:0] code_index;
		logic [3:0] cable;
	} packet_t;

endpackage
`default_nettype wire

/* rtl/serial_midi_to_usb_midi_packets.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// serial_midi_to_usb_midi_packets
// Parses a serial MIDI byte stream into 4-byte USB-MIDI event packets.
// ----------------------------------------------------------------------------
// One MIDI byte is taken per beat on the slave side and one packet per beat
// leaves on the master side. The block accepts a byte in every cycle unless
// the output register holds it back. A byte is parsed in the cycle after its
// beat, and its packet, if any, is loaded into the output register when the
// byte advances. The only thing that slows the input is the output register:
// when it holds a packet that is not taken and the parsed byte makes another,
// input ready drops until the master side drains.
// cable_number is written through the cfg channel, which is always ready;
// write it only while idle.
module serial_midi_to_usb_midi_packets
	import smum_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] midi_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [3:0] cable, [7:4] code_index,
	                                    // [15:8] first_byte, [23:16] second_byte,
	                                    // [31:24] third_byte
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_data   // [3:0] cable_number
);

	logic       cfg_wr;
	logic [3:0] cable_num_q;
	logic       in_valid_s1;
	logic [7:0] byte_s1;
	phase_t     phase_q, phase_d;
	logic [7:0] held1_q, held1_d;
	logic [7:0] held2_q, held2_d;
	logic       emit_c;
	packet_t    pkt_c, pkt_q;
	logic       out_free;
	logic       advance;

	// configuration
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cable_num_q <= '0;
		end else if (cfg_wr) begin
			cable_num_q <= cfg_data;
		end
	end

	// handshake between input register and output register
	assign out_free = ~m_tvalid | m_tready;
	assign advance  = in_valid_s1 & (out_free | ~emit_c);
	assign s_tready = ~in_valid_s1 | advance;

	// parser
	always_comb begin
		emit_c           = 1'b0;
		phase_d          = phase_q;
		held1_d          = held1_q;
		held2_d          = held2_q;
		pkt_c            = '0;
		pkt_c.cable      = cable_num_q;
		if (byte_s1 >= ST_RT_LOW) begin
			// real-time passes at once, state kept
			emit_c           = 1'b1;
			pkt_c.code_index = CIN_RT;
			pkt_c.first_byte = byte_s1;
		end else if (byte_s1[7:4] == NIB_SYSTEM) begin
			unique case (byte_s1) inside
				ST_SX_START: begin
					held1_d = byte_s1;
					phase_d = PH_SX1;
				end
				ST_MTC, ST_SONG: begin
					held1_d = byte_s1;
					phase_d = PH_ONE;
				end
				ST_SPP: begin
					held1_d = byte_s1;
					phase_d = PH_TWO_A;
				end
				ST_TUNE: begin
					phase_d          = PH_UNKNOWN;
					emit_c           = 1'b1;
					pkt_c.code_index = CIN_SX_END1;
					pkt_c.first_byte = ST_TUNE;
				end
				ST_SX_END: begin
					// close sysex by pending count
					phase_d = PH_UNKNOWN;
					case (phase_q)
						PH_SX0: begin
							emit_c           = 1'b1;
							pkt_c.code_index = CIN_SX_END1;
							pkt_c.first_byte = ST_SX_END;
						end
						PH_SX1: begin
							emit_c            = 1'b1;
							pkt_c.code_index  = CIN_SX_END2;
							pkt_c.first_byte  = held1_q;
							pkt_c.second_byte = ST_SX_END;
						end
						PH_SX2: begin
							emit_c            = 1'b1;
							pkt_c.code_index  = CIN_SX_END3;
							pkt_c.first_byte  = held1_q;
							pkt_c.second_byte = held2_q;
							pkt_c.third_byte  = ST_SX_END;
						end
						default: ;
					endcase
				end
				default: begin
					// undefined status
					phase_d = PH_UNKNOWN;
				end
			endcase
		end else if (byte_s1[7]) begin
			// channel status
			held1_d = byte_s1;
			phase_d = (byte_s1 >= ST_ONE_LOW && byte_s1 <= ST_ONE_HIGH) ? PH_ONE : PH_TWO_A;
		end else begin
			// data byte
			unique case (phase_q)
				PH_ONE: begin
					emit_c            = 1'b1;
					pkt_c.first_byte  = held1_q;
					pkt_c.second_byte = byte_s1;
					if (held1_q[7:4] != NIB_SYSTEM) begin
						pkt_c.code_index = held1_q[7:4];
					end else begin
						pkt_c.code_index = CIN_SYS_TWO;
						phase_d          = PH_UNKNOWN;
					end
				end
				PH_TWO_A: begin
					held2_d = byte_s1;
					phase_d = PH_TWO_B;
				end
				PH_TWO_B: begin
					emit_c            = 1'b1;
					pkt_c.first_byte  = held1_q;
					pkt_c.second_byte = held2_q;
					pkt_c.third_byte  = byte_s1;
					if (held1_q[7:4] != NIB_SYSTEM) begin
						pkt_c.code_index = held1_q[7:4];
						phase_d          = PH_TWO_A;
					end else begin
						pkt_c.code_index = CIN_SYS_THREE;
						phase_d          = PH_UNKNOWN;
					end
				end
				PH_SX0: begin
					held1_d = byte_s1;
					phase_d = PH_SX1;
				end
				PH_SX1: begin
					held2_d = byte_s1;
					phase_d = PH_SX2;
				end
				PH_SX2: begin
					emit_c            = 1'b1;
					pkt_c.code_index  = CIN_SX_START;
					pkt_c.first_byte  = held1_q;
					pkt_c.second_byte = held2_q;
					pkt_c.third_byte  = byte_s1;
					phase_d           = PH_SX0;
				end
				default: begin
					// stray data byte
					phase_d = PH_UNKNOWN;
				end
			endcase
		end
	end

	// input register, parser state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			phase_q     <= PH_UNKNOWN;
			held1_q     <= '0;
			held2_q     <= '0;
			m_tvalid    <= 1'b0;
		end else begin
			if (s_tready) begin
				in_valid_s1 <= s_tvalid;
			end
			if (advance) begin
				phase_q <= phase_d;
				held1_q <= held1_d;
				held2_q <= held2_d;
			end
			if (advance && emit_c) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
		if (advance && emit_c) begin
			pkt_q <= pkt_c;
		end
	end

	assign m_tdata = pkt_q;

`ifndef ASSERT_OFF
	// a parsed packet that finds the output full holds back the input
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && emit_c && m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted while a packet is blocked");

	// every emitted packet shows up on the master side
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit_c |=> m_tvalid)
		else $error("emitted packet lost");

	// real-time bytes leave the parser state alone
	a_rt_keeps_phase: assert property (@(posedge clk) disable iff (!arst_n)
		advance && byte_s1 >= ST_RT_LOW |=> $stable(phase_q) && $stable(held1_q))
		else $error("real-time byte disturbed parser state");
`endif

endmodule
`default_nettype wire
